// ----- rtl/core/pcc_pkg.sv -----
// Shared types, constants and width helpers for the polar/Cartesian converter.
// Used by every module under rtl/core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pcc_pkg;

    localparam int ROTATION_STEPS_DEF = 16;
    localparam int COORD_WIDTH_DEF    = 32;

    // guard fraction bits carried through the rotation datapath
    localparam int GUARD          = 8;
    localparam int PRESCALE_SHIFT = 30 - GUARD;
    localparam int HEADROOM       = 3;
    localparam int QUEUE_DEPTH    = 4;

    // reciprocal of the CORDIC gain (1/K), Q2.30
    localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

    localparam logic [15:0] HALF_TURN_BAM = 16'h8000;
    localparam logic [31:0] HALF_TURN_Z   = 32'h8000_0000;
    localparam logic [31:0] ANGLE_ROUND   = 32'h0000_8000;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef enum logic {
        KIND_TO_POLAR = 1'b0,
        KIND_TO_CART  = 1'b1
    } kind_t;

    // fields that ride alongside the rotation datapath
    typedef struct packed {
        kind_t       kind;
        logic        zero;
        logic [31:0] echo_x;
        logic [31:0] echo_y;
        logic [15:0] angle;
        logic [30:0] magnitude;
    } side_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic int cw_eff(input int cw);
        return (cw < 32) ? cw : 32;
    endfunction

    function automatic int int_width(input int cw);
        return cw_eff(cw) + GUARD + HEADROOM;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pcc_front.sv -----
// Front end: takes input words, classifies by kind, folds sign and quadrant,
// and applies the gain prescale. Depends on pcc_pkg; feeds pcc_queue.
`timescale 1ns / 1ps
`default_nettype none

module pcc_front #(
    parameter  int COORD_WIDTH = pcc_pkg::COORD_WIDTH_DEF,
    localparam int IW          = pcc_pkg::int_width(COORD_WIDTH)
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_kind,
    input  wire logic signed [31:0]    s_x_in,
    input  wire logic signed [31:0]    s_y_in,
    input  wire logic signed [31:0]    s_magnitude_in,
    input  wire logic signed [15:0]    s_angle_in,
    input  wire pcc_pkg::q_stat_t      q_stat,
    output logic                       q_push,
    output pcc_pkg::side_t             q_side,
    output logic signed [IW-1:0]       q_x,
    output logic signed [IW-1:0]       q_y,
    output logic [31:0]                q_z
);

    localparam int CW = pcc_pkg::cw_eff(COORD_WIDTH);
    localparam int PW = CW + 32;
    localparam logic signed [CW:0] MAXC = (CW+1)'((64'sd1 <<< (CW - 1)) - 64'sd1);

    logic                en;
    logic [2:0]          v_reg;

    logic signed [CW:0]  xs, ys, ms, mm;
    logic [15:0]         ang_a;
    logic signed [CW:0]  px_next, py_next;
    logic [31:0]         z_next;
    logic                negx_next;
    pcc_pkg::side_t      side_next;

    logic signed [CW:0]  px1_reg, py1_reg;
    logic [31:0]         z1_reg, z2_reg, z3_reg;
    logic                negx1_reg, negx2_reg;
    pcc_pkg::side_t      side1_reg, side2_reg, side3_reg;

    logic signed [PW-1:0] prodx_next, prody_next;
    logic signed [PW-1:0] prodx_reg, prody_reg;
    logic signed [PW-1:0] shx, shy;
    logic signed [IW-1:0] x3_next, y3_next;
    logic signed [IW-1:0] x3_reg, y3_reg;

    assign en      = !v_reg[2] || !q_stat.full;
    assign s_ready = en;
    assign q_push  = v_reg[2] && !q_stat.full;

    always_comb begin
        xs        = {s_x_in[CW-1], s_x_in[CW-1:0]};
        ys        = {s_y_in[CW-1], s_y_in[CW-1:0]};
        ms        = {s_magnitude_in[CW-1], s_magnitude_in[CW-1:0]};
        mm        = ms;
        ang_a     = s_angle_in;
        px_next   = xs;
        py_next   = ys;
        z_next    = '0;
        negx_next = 1'b0;

        side_next.kind      = pcc_pkg::kind_t'(s_kind);
        side_next.zero      = (xs == '0) && (ys == '0);
        side_next.echo_x    = 32'(xs);
        side_next.echo_y    = 32'(ys);
        side_next.angle     = '0;
        side_next.magnitude = '0;

        if (side_next.kind == pcc_pkg::KIND_TO_CART) begin
            if (ms[CW]) begin
                mm    = -ms;
                ang_a = s_angle_in + pcc_pkg::HALF_TURN_BAM;
            end
            if (mm > MAXC) begin
                mm = MAXC;
            end
            side_next.zero      = 1'b0;
            side_next.echo_x    = '0;
            side_next.echo_y    = '0;
            side_next.angle     = ang_a;
            side_next.magnitude = 31'(mm);
            // fold the left half plane onto the right one
            negx_next = ang_a[15] ^ ang_a[14];
            z_next    = {ang_a[15] ^ negx_next, ang_a[14:0], 16'h0000};
            px_next   = mm;
            py_next   = '0;
        end else if (xs[CW]) begin
            px_next = -xs;
            py_next = -ys;
            z_next  = pcc_pkg::HALF_TURN_Z;
        end
    end

    assign prodx_next = PW'(px1_reg) * PW'(pcc_pkg::GAIN_Q30);
    assign prody_next = PW'(py1_reg) * PW'(pcc_pkg::GAIN_Q30);

    assign shx     = prodx_reg >>> pcc_pkg::PRESCALE_SHIFT;
    assign shy     = prody_reg >>> pcc_pkg::PRESCALE_SHIFT;
    assign x3_next = IW'(negx2_reg ? -shx : shx);
    assign y3_next = IW'(shy);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[1:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px1_reg   <= px_next;
            py1_reg   <= py_next;
            z1_reg    <= z_next;
            negx1_reg <= negx_next;
            side1_reg <= side_next;

            prodx_reg <= prodx_next;
            prody_reg <= prody_next;
            z2_reg    <= z1_reg;
            negx2_reg <= negx1_reg;
            side2_reg <= side1_reg;

            x3_reg    <= x3_next;
            y3_reg    <= y3_next;
            z3_reg    <= z2_reg;
            side3_reg <= side2_reg;
        end
    end

    assign q_side = side3_reg;
    assign q_x    = x3_reg;
    assign q_y    = y3_reg;
    assign q_z    = z3_reg;

endmodule

`default_nettype wire

// ----- rtl/core/pcc_queue.sv -----
// Short word queue between the front end and the rotation pipeline.
// Depends on pcc_pkg; written by pcc_front, read by pcc_back.
`timescale 1ns / 1ps
`default_nettype none

module pcc_queue #(
    parameter  int COORD_WIDTH = pcc_pkg::COORD_WIDTH_DEF,
    localparam int IW          = pcc_pkg::int_width(COORD_WIDTH)
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire pcc_pkg::side_t        wr_side,
    input  wire logic signed [IW-1:0]  wr_x,
    input  wire logic signed [IW-1:0]  wr_y,
    input  wire logic [31:0]           wr_z,
    input  wire logic                  pop,
    output pcc_pkg::side_t             rd_side,
    output logic signed [IW-1:0]       rd_x,
    output logic signed [IW-1:0]       rd_y,
    output logic [31:0]                rd_z,
    output pcc_pkg::q_stat_t           q_stat
);

    localparam int DEPTH = pcc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    pcc_pkg::side_t       side_mem_reg [DEPTH];
    logic signed [IW-1:0] x_mem_reg    [DEPTH];
    logic signed [IW-1:0] y_mem_reg    [DEPTH];
    logic [31:0]          z_mem_reg    [DEPTH];

    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            side_mem_reg[wr_ptr_reg] <= wr_side;
            x_mem_reg[wr_ptr_reg]    <= wr_x;
            y_mem_reg[wr_ptr_reg]    <= wr_y;
            z_mem_reg[wr_ptr_reg]    <= wr_z;
        end
    end

    assign rd_side      = side_mem_reg[rd_ptr_reg];
    assign rd_x         = x_mem_reg[rd_ptr_reg];
    assign rd_y         = y_mem_reg[rd_ptr_reg];
    assign rd_z         = z_mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);

endmodule

`default_nettype wire

// ----- rtl/core/pcc_back.sv -----
// Back end: one CORDIC micro-rotation per pipeline stage, then rounding,
// saturation and the result output register. Depends on pcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcc_back #(
    parameter  int ROTATION_STEPS = pcc_pkg::ROTATION_STEPS_DEF,
    parameter  int COORD_WIDTH    = pcc_pkg::COORD_WIDTH_DEF,
    localparam int IW             = pcc_pkg::int_width(COORD_WIDTH)
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire pcc_pkg::q_stat_t      q_stat,
    input  wire pcc_pkg::side_t        q_side,
    input  wire logic signed [IW-1:0]  q_x,
    input  wire logic signed [IW-1:0]  q_y,
    input  wire logic [31:0]           q_z,
    output logic                       q_pop,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic signed [31:0]         m_x_out,
    output logic signed [31:0]         m_y_out,
    output logic signed [15:0]         m_angle_out,
    output logic [30:0]                m_magnitude_out
);

    localparam int N  = ROTATION_STEPS;
    localparam int CW = pcc_pkg::cw_eff(COORD_WIDTH);
    localparam logic signed [IW-1:0] MAXC = IW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [IW-1:0] MINC = -MAXC - IW'(1);
    localparam logic signed [IW-1:0] RND  = IW'(64'sd1 <<< (pcc_pkg::GUARD - 1));

    logic                 en;
    logic [N-1:0]         v_reg;
    logic signed [IW-1:0] x_reg    [N];
    logic signed [IW-1:0] y_reg    [N];
    logic [31:0]          z_reg    [N];
    pcc_pkg::side_t       side_reg [N];

    logic                 m_valid_reg;
    logic signed [31:0]   m_x_out_reg, m_y_out_reg, m_x_out_next, m_y_out_next;
    logic [15:0]          m_angle_out_reg, m_angle_out_next;
    logic [30:0]          m_magnitude_out_reg, m_magnitude_out_next;

    logic signed [IW-1:0] xl, yl, rx, ry, sx, sy, mg;
    logic [31:0]          zl, zr;
    pcc_pkg::side_t       sl;

    assign en    = !m_valid_reg || m_ready;
    assign q_pop = en && !q_stat.empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[N-2:0], !q_stat.empty};
        end
    end

    for (genvar j = 0; j < N; j++) begin : g_stage
        logic signed [IW-1:0] xi, yi, x_next, y_next, dx, dy;
        logic [31:0]          zi, z_next;
        pcc_pkg::side_t       si;
        logic                 turn_pos;

        if (j == 0) begin : g_head
            assign xi = q_x;
            assign yi = q_y;
            assign zi = q_z;
            assign si = q_side;
        end else begin : g_chain
            assign xi = x_reg[j-1];
            assign yi = y_reg[j-1];
            assign zi = z_reg[j-1];
            assign si = side_reg[j-1];
        end

        assign dx       = yi >>> j;
        assign dy       = xi >>> j;
        assign turn_pos = (si.kind == pcc_pkg::KIND_TO_CART) ? zi[31] : !yi[IW-1];
        assign x_next   = turn_pos ? xi + dx : xi - dx;
        assign y_next   = turn_pos ? yi - dy : yi + dy;
        assign z_next   = turn_pos ? zi + pcc_pkg::ATAN_TAB[j] : zi - pcc_pkg::ATAN_TAB[j];

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[j]    <= x_next;
                y_reg[j]    <= y_next;
                z_reg[j]    <= z_next;
                side_reg[j] <= si;
            end
        end
    end

    always_comb begin
        xl = x_reg[N-1];
        yl = y_reg[N-1];
        zl = z_reg[N-1];
        sl = side_reg[N-1];
        rx = (xl + RND) >>> pcc_pkg::GUARD;
        ry = (yl + RND) >>> pcc_pkg::GUARD;
        sx = (rx > MAXC) ? MAXC : ((rx < MINC) ? MINC : rx);
        sy = (ry > MAXC) ? MAXC : ((ry < MINC) ? MINC : ry);
        mg = xl[IW-1] ? '0 : ((rx > MAXC) ? MAXC : rx);
        zr = zl + pcc_pkg::ANGLE_ROUND;

        if (sl.kind == pcc_pkg::KIND_TO_CART) begin
            m_x_out_next         = 32'(sx);
            m_y_out_next         = 32'(sy);
            m_angle_out_next     = sl.angle;
            m_magnitude_out_next = sl.magnitude;
        end else begin
            m_x_out_next = sl.echo_x;
            m_y_out_next = sl.echo_y;
            if (sl.zero) begin
                m_angle_out_next     = '0;
                m_magnitude_out_next = '0;
            end else begin
                m_angle_out_next     = zr[31:16];
                m_magnitude_out_next = 31'(mg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v_reg[N-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_x_out_reg         <= m_x_out_next;
            m_y_out_reg         <= m_y_out_next;
            m_angle_out_reg     <= m_angle_out_next;
            m_magnitude_out_reg <= m_magnitude_out_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_x_out         = m_x_out_reg;
    assign m_y_out         = m_y_out_reg;
    assign m_angle_out     = m_angle_out_reg;
    assign m_magnitude_out = m_magnitude_out_reg;

endmodule

`default_nettype wire

// ----- rtl/core/polar_cartesian_converter_core.sv -----
// Top level of the polar/Cartesian converter: front end, word queue, back end.
// Depends on pcc_pkg, pcc_front, pcc_queue and pcc_back.
`timescale 1ns / 1ps
`default_nettype none

// Converts one vector per word: kind 0 gives atan2 angle and saturated magnitude of (x, y)
// and echoes x and y; kind 1 gives x and y from an angle and a signed magnitude. A new
// word is taken every cycle while s_ready is high; the path from accept to result is
// three front stages (fold, gain multiply, shift), the four-word queue, one pipeline
// stage per CORDIC micro-rotation, and the output register.
// Back-pressure on the result side fills the queue first and then stops s_ready.

module polar_cartesian_converter_core #(
    parameter int ROTATION_STEPS = pcc_pkg::ROTATION_STEPS_DEF,
    parameter int COORD_WIDTH    = pcc_pkg::COORD_WIDTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_kind,
    input  wire logic signed [31:0] s_x_in,
    input  wire logic signed [31:0] s_y_in,
    input  wire logic signed [31:0] s_magnitude_in,
    input  wire logic signed [15:0] s_angle_in,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_x_out,
    output logic signed [31:0]      m_y_out,
    output logic signed [15:0]      m_angle_out,
    output logic [30:0]             m_magnitude_out
);

    localparam int IW = pcc_pkg::int_width(COORD_WIDTH);

    pcc_pkg::q_stat_t     q_stat;
    logic                 q_push, q_pop;
    pcc_pkg::side_t       wr_side, rd_side;
    logic signed [IW-1:0] wr_x, wr_y, rd_x, rd_y;
    logic [31:0]          wr_z, rd_z;

    pcc_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_x_in         (s_x_in),
        .s_y_in         (s_y_in),
        .s_magnitude_in (s_magnitude_in),
        .s_angle_in     (s_angle_in),
        .q_stat         (q_stat),
        .q_push         (q_push),
        .q_side         (wr_side),
        .q_x            (wr_x),
        .q_y            (wr_y),
        .q_z            (wr_z)
    );

    pcc_queue #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_side (wr_side),
        .wr_x    (wr_x),
        .wr_y    (wr_y),
        .wr_z    (wr_z),
        .pop     (q_pop),
        .rd_side (rd_side),
        .rd_x    (rd_x),
        .rd_y    (rd_y),
        .rd_z    (rd_z),
        .q_stat  (q_stat)
    );

    pcc_back #(
        .ROTATION_STEPS (ROTATION_STEPS),
        .COORD_WIDTH    (COORD_WIDTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_stat          (q_stat),
        .q_side          (rd_side),
        .q_x             (rd_x),
        .q_y             (rd_y),
        .q_z             (rd_z),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_x_out         (m_x_out),
        .m_y_out         (m_y_out),
        .m_angle_out     (m_angle_out),
        .m_magnitude_out (m_magnitude_out)
    );

    a_queue_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty))
        else $error("queue flags full and empty together");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_stat.full)
        else $error("word pushed into full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("word popped from empty queue");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire

// ----- tb/polar_cartesian_converter_core_tb.sv -----
// Self-checking bench for polar_cartesian_converter_core: a bit-exact CORDIC model
// predicts each result word; random source gaps and sink stalls stress the handshake.
// Depends on pcc_pkg and the converter RTL.
`timescale 1ns / 1ps

module polar_cartesian_converter_core_tb;

    localparam int ROTATION_STEPS = 16;
    localparam int COORD_WIDTH    = 32;
    localparam int COORD_EFF      = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam longint COORD_MAX  = (longint'(1) <<< (COORD_EFF - 1)) - 1;
    localparam longint CORDIC_GAIN = 652032874;
    localparam int GUARD_BITS     = 8;
    localparam bit [31:0] HALF_TURN = 32'h8000_0000;
    localparam int LATENCY        = ROTATION_STEPS + 5;
    localparam int RANDOM_WORDS   = 1625;
    localparam int CYCLE_LIMIT    = 200_000;

    localparam bit [31:0] ROT_ANGLE [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct {
        pcc_pkg::kind_t     kind;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] magnitude;
        logic [15:0]        angle;
    } vec_word_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [15:0]        angle;
        logic [30:0]        magnitude;
    } vec_result_t;

    class conversion_scoreboard;
        vec_result_t expected_results[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        static function longint fit_coord(logic signed [31:0] v);
            longint t;
            t = longint'(v);
            return (t <<< (64 - COORD_EFF)) >>> (64 - COORD_EFF);
        endfunction

        static function longint scale_by_gain(longint v);
            return (v * CORDIC_GAIN) >>> (30 - GUARD_BITS);
        endfunction

        static function longint strip_guard(longint v);
            return (v + (longint'(1) <<< (GUARD_BITS - 1))) >>> GUARD_BITS;
        endfunction

        static function longint clamp_coord(longint v);
            if (v > COORD_MAX) return COORD_MAX;
            if (v < -COORD_MAX - 1) return -COORD_MAX - 1;
            return v;
        endfunction

        static function vec_result_t convert_vector(vec_word_t w);
            vec_result_t r;
            longint xs, ys, cx, cy, dx, dy, m, t;
            bit [31:0] z, zq;
            bit [15:0] a;
            int i, s;
            if (w.kind == pcc_pkg::KIND_TO_POLAR) begin
                xs = fit_coord(w.x);
                ys = fit_coord(w.y);
                r.x = xs[31:0];
                r.y = ys[31:0];
                if (xs == 0 && ys == 0) begin
                    r.angle = '0;
                    r.magnitude = '0;
                end else begin
                    z = '0;
                    if (xs < 0) begin
                        xs = -xs;
                        ys = -ys;
                        z = HALF_TURN;
                    end
                    cx = scale_by_gain(xs);
                    cy = scale_by_gain(ys);
                    for (i = 0; i < ROTATION_STEPS; i++) begin
                        s = i % 32;
                        dx = cy >>> s;
                        dy = cx >>> s;
                        if (cy >= 0) begin
                            cx = cx + dx;
                            cy = cy - dy;
                            z = z + ROT_ANGLE[s];
                        end else begin
                            cx = cx - dx;
                            cy = cy + dy;
                            z = z - ROT_ANGLE[s];
                        end
                    end
                    zq = z + 32'h0000_8000;
                    r.angle = zq[31:16];
                    m = (cx < 0) ? 0 : strip_guard(cx);
                    if (m > COORD_MAX) m = COORD_MAX;
                    r.magnitude = m[30:0];
                end
            end else begin
                m = fit_coord(w.magnitude);
                a = w.angle;
                if (m < 0) begin
                    m = -m;
                    a = a + 16'h8000;
                end
                if (m > COORD_MAX) m = COORD_MAX;
                r.magnitude = m[30:0];
                r.angle = a;
                z = {a, 16'h0000};
                cx = scale_by_gain(m);
                cy = 0;
                zq = z + 32'h4000_0000;
                if (zq[31]) begin
                    z = z + HALF_TURN;
                    cx = -cx;
                end
                for (i = 0; i < ROTATION_STEPS; i++) begin
                    s = i % 32;
                    dx = cy >>> s;
                    dy = cx >>> s;
                    if (z[31]) begin
                        cx = cx + dx;
                        cy = cy - dy;
                        z = z + ROT_ANGLE[s];
                    end else begin
                        cx = cx - dx;
                        cy = cy + dy;
                        z = z - ROT_ANGLE[s];
                    end
                end
                t = clamp_coord(strip_guard(cx));
                r.x = t[31:0];
                t = clamp_coord(strip_guard(cy));
                r.y = t[31:0];
            end
            return r;
        endfunction

        function void note_input(vec_word_t w);
            expected_results.push_back(convert_vector(w));
        endfunction

        function void check_result(vec_result_t got);
            vec_result_t want;
            if (expected_results.size() == 0) begin
                $error("result word with no conversion pending");
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            if (got.x !== want.x) begin
                $error("x_out: expected %0d, got %0d", want.x, got.x);
                mismatches++;
            end
            if (got.y !== want.y) begin
                $error("y_out: expected %0d, got %0d", want.y, got.y);
                mismatches++;
            end
            if (got.angle !== want.angle) begin
                $error("angle_out: expected %0d, got %0d", want.angle, got.angle);
                mismatches++;
            end
            if (got.magnitude !== want.magnitude) begin
                $error("magnitude_out: expected %0d, got %0d", want.magnitude, got.magnitude);
                mismatches++;
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_kind;
    logic signed [31:0] s_x_in;
    logic signed [31:0] s_y_in;
    logic signed [31:0] s_magnitude_in;
    logic signed [15:0] s_angle_in;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_x_out;
    logic signed [31:0] m_y_out;
    logic signed [15:0] m_angle_out;
    logic [30:0]        m_magnitude_out;

    conversion_scoreboard conversions = new();
    vec_word_t   taken_word;
    vec_result_t seen_result;
    bit          in_taken;
    bit          no_gaps;
    int unsigned cycle_count;

    polar_cartesian_converter_core #(
        .ROTATION_STEPS(ROTATION_STEPS),
        .COORD_WIDTH   (COORD_WIDTH)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_x_in         (s_x_in),
        .s_y_in         (s_y_in),
        .s_magnitude_in (s_magnitude_in),
        .s_angle_in     (s_angle_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_x_out        (m_x_out),
        .m_y_out        (m_y_out),
        .m_angle_out    (m_angle_out),
        .m_magnitude_out(m_magnitude_out)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge aclk) begin
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            taken_word.kind      = pcc_pkg::kind_t'(s_kind);
            taken_word.x         = s_x_in;
            taken_word.y         = s_y_in;
            taken_word.magnitude = s_magnitude_in;
            taken_word.angle     = s_angle_in;
            conversions.note_input(taken_word);
        end
        if (aresetn && m_valid && m_ready) begin
            seen_result.x         = m_x_out;
            seen_result.y         = m_y_out;
            seen_result.angle     = m_angle_out;
            seen_result.magnitude = m_magnitude_out;
            conversions.check_result(seen_result);
        end
    end

    always @(negedge aclk) begin
        m_ready <= no_gaps || ($urandom_range(99) >= 35);
    end

    function automatic vec_word_t to_polar(logic signed [31:0] x, logic signed [31:0] y);
        vec_word_t w;
        w.kind      = pcc_pkg::KIND_TO_POLAR;
        w.x         = x;
        w.y         = y;
        w.magnitude = $urandom;
        w.angle     = 16'($urandom);
        return w;
    endfunction

    function automatic vec_word_t to_cart(logic signed [31:0] m, logic [15:0] a);
        vec_word_t w;
        w.kind      = pcc_pkg::KIND_TO_CART;
        w.x         = $urandom;
        w.y         = $urandom;
        w.magnitude = m;
        w.angle     = a;
        return w;
    endfunction

    function automatic logic signed [31:0] pick_coord();
        logic signed [31:0] v;
        case ($urandom_range(9))
            0: v = 32'sh8000_0000;
            1: v = 32'sh7FFF_FFFF;
            2: v = '0;
            3, 4, 5: v = $signed($urandom) >>> $urandom_range(31);
            default: v = $signed($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [15:0] pick_angle();
        logic [15:0] a;
        if ($urandom_range(3) == 0) begin
            a = 16'($urandom_range(3)) << 14;
            a = a + 16'($urandom_range(4)) - 16'd2;
        end else begin
            a = 16'($urandom);
        end
        return a;
    endfunction

    task automatic send_word(vec_word_t w);
        while (!no_gaps && $urandom_range(99) < 35) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_kind         <= w.kind;
        s_x_in         <= w.x;
        s_y_in         <= w.y;
        s_magnitude_in <= w.magnitude;
        s_angle_in     <= w.angle;
        do @(negedge aclk); while (!in_taken);
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_kind         = pcc_pkg::KIND_TO_POLAR;
        s_x_in         = '0;
        s_y_in         = '0;
        s_magnitude_in = '0;
        s_angle_in     = '0;
        m_ready        = 1'b0;
        in_taken       = 1'b0;
        no_gaps        = 1'b0;
        cycle_count    = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_word(to_polar(32'sd0, 32'sd0));
        send_word(to_polar(32'sd65536, 32'sd0));
        send_word(to_polar(32'sd0, 32'sd65536));
        send_word(to_polar(-32'sd65536, 32'sd0));
        send_word(to_polar(32'sd0, -32'sd65536));
        send_word(to_polar(-32'sd1, 32'sd0));
        send_word(to_polar(32'sd7, -32'sd5));
        send_word(to_polar(-32'sd196608, 32'sd262144));
        send_word(to_polar(32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        send_word(to_polar(32'sh8000_0000, 32'sh8000_0000));
        send_word(to_polar(32'sh8000_0000, 32'sd0));
        send_word(to_polar(32'sd0, 32'sh8000_0000));
        send_word(to_polar(32'sh7FFF_FFFF, 32'sh8000_0000));
        send_word(to_polar(32'sh8000_0000, 32'sh7FFF_FFFF));
        send_word(to_cart(32'sd0, 16'h0000));
        send_word(to_cart(32'sd65536, 16'h0000));
        send_word(to_cart(32'sd65536, 16'h4000));
        send_word(to_cart(32'sd65536, 16'h8000));
        send_word(to_cart(32'sd65536, 16'h7FFF));
        send_word(to_cart(-32'sd65536, 16'h2000));
        send_word(to_cart(-32'sd1, 16'hFFFF));
        send_word(to_cart(32'sh7FFF_FFFF, 16'h0000));
        send_word(to_cart(32'sh7FFF_FFFF, 16'h8000));
        send_word(to_cart(32'sh7FFF_FFFF, 16'h2000));
        send_word(to_cart(32'sh8000_0000, 16'h4000));

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            no_gaps = (n >= 700 && n < 1000);
            if ($urandom_range(1) == 0)
                send_word(to_polar(pick_coord(), pick_coord()));
            else
                send_word(to_cart(pick_coord(), pick_angle()));
        end
        s_valid <= 1'b0;
        no_gaps = 1'b0;

        while (conversions.expected_results.size() != 0) @(negedge aclk);
        repeat (2 * LATENCY) @(negedge aclk);

        if (conversions.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/pcc_pkg.sv
rtl/core/pcc_front.sv
rtl/core/pcc_queue.sv
rtl/core/pcc_back.sv
rtl/core/polar_cartesian_converter_core.sv
tb/polar_cartesian_converter_core_tb.sv
